// ===== rtl/core/mmpl2_pkg.sv =====
// ----------------------------------------------------------------------------
// mmpl2_pkg: shared types and constants
// Fixed widths and command/status structs for the pooling block.
// ----------------------------------------------------------------------------
package mmpl2_pkg;

    localparam int unsigned ValW  = 24;
    localparam int unsigned SumW  = 34;
    localparam int unsigned OutW  = 23;
    localparam int unsigned IdxW  = 6;
    localparam int unsigned SqW   = 64;
    localparam int unsigned RootW = 32;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_ACCUM = 3'd1,
        OP_MEAN  = 3'd2,
        OP_SQRT  = 3'd3,
        OP_OUT   = 3'd4
    } t_op;

    typedef struct packed {
        t_op op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sts;

endpackage

// ===== rtl/core/mmpl2_if.sv =====
// ----------------------------------------------------------------------------
// mmpl2_if: valid/ready channel
// Carries one request payload between a source and a sink.
// ----------------------------------------------------------------------------
interface mmpl2_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mmpl2_ram.sv =====
// ----------------------------------------------------------------------------
// mmpl2_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mmpl2_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage with registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/mmpl2_divu.sv =====
// ----------------------------------------------------------------------------
// mmpl2_divu: radix-2 unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmpl2_divu #(
    parameter int unsigned NW = 64,
    parameter int unsigned DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   r_rem, n_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [DW+1:0] w_try;

    // one trial subtraction per cycle
    always_comb begin
        w_try = {r_rem, r_quo[NW-1]} - {2'b00, r_den};
        n_quo = {r_quo[NW-2:0], ~w_try[DW+1]};
        n_rem = w_try[DW+1] ? {r_rem[DW-1:0], r_quo[NW-1]} : w_try[DW:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/core/mmpl2_dp.sv =====
// ----------------------------------------------------------------------------
// mmpl2_dp: pooling datapath
// Sum memory, mean memory, kept count, shared divider, root unit and output stage.
// ----------------------------------------------------------------------------
module mmpl2_dp #(
    parameter int unsigned DIM        = 64,
    parameter int unsigned MAX_TOKENS = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmpl2_pkg::t_cmd                     i_cmd,
    output mmpl2_pkg::t_sts                     o_sts,
    input  logic signed [mmpl2_pkg::ValW-1:0]   i_val,
    input  logic                                i_keep,
    output logic                                o_clear_busy,
    output logic signed [mmpl2_pkg::OutW-1:0]   o_res,
    output logic [mmpl2_pkg::IdxW-1:0]          o_idx,
    output logic                                o_last,
    output logic                                o_res_valid,
    input  logic                                i_res_ready
);
    localparam int unsigned AW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int unsigned KW = $clog2(MAX_TOKENS + 1);
    localparam int unsigned SumW = mmpl2_pkg::SumW;
    localparam int unsigned ValW = mmpl2_pkg::ValW;
    localparam int unsigned OutW = mmpl2_pkg::OutW;
    localparam int unsigned SqW  = mmpl2_pkg::SqW;
    localparam int unsigned RW   = mmpl2_pkg::RootW;
    localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_ACC_RD, S_ACC_WR, S_MRD, S_MWAIT, S_MDIV,
        S_ROOT, S_ORD, S_OWAIT, S_ODIV, S_OSEND
    } t_dst;

    t_dst r_st;
    logic [AW-1:0] r_pos, r_addr;
    logic [KW-1:0] r_kept;
    logic r_keep;
    logic signed [ValW-1:0] r_val;
    logic signed [SumW-1:0] w_rd, w_sum;
    logic [SumW:0] w_wide;
    logic w_we;
    logic [SumW-1:0] w_wdata;
    logic [ValW-1:0] w_mrd;
    logic signed [ValW-1:0] w_mean;
    logic w_mwe;
    logic [SqW-1:0] r_sq;
    logic [2*ValW-1:0] r_msq;
    logic r_msq_v;
    logic [63:0] w_num, w_quo;
    logic [RW-1:0] w_den;
    logic r_dstart, w_ddone, r_neg;
    logic [RW-1:0] r_root;
    logic [5:0] r_rcnt;
    logic signed [OutW-1:0] r_res;
    logic r_rv, r_done;
    logic [AW-1:0] r_oidx;
    logic [SqW+9:0] r_sx;
    logic [RW+1:0]  r_srem;
    logic [RW-1:0]  r_sres;

    // sum memory and mean memory
    mmpl2_ram #(.WIDTH(SumW), .DEPTH(1 << AW)) u_sum (
        .i_clk(i_clk), .i_we(w_we), .i_addr(r_addr), .i_wdata(w_wdata), .o_rdata(w_rd)
    );
    mmpl2_ram #(.WIDTH(ValW), .DEPTH(1 << AW)) u_mean (
        .i_clk(i_clk), .i_we(w_mwe), .i_addr(r_addr), .i_wdata(w_mean), .o_rdata(w_mrd)
    );

    // saturating accumulate
    always_comb begin
        w_wide = {w_rd[SumW-1], w_rd} + {{(SumW+1-ValW){r_val[ValW-1]}}, r_val};
        priority if (w_wide[SumW] != w_wide[SumW-1]) begin
            w_sum = w_wide[SumW] ? SumMin : SumMax;
        end else begin
            w_sum = w_wide[SumW-1:0];
        end
        w_we    = (r_st == S_CLR) || (r_st == S_ACC_WR && r_keep);
        w_wdata = (r_st == S_CLR) ? '0 : w_sum;
        w_mwe   = (r_st == S_MDIV) && (w_ddone || r_kept == '0);
    end

    // clamped signed mean from the divider quotient
    always_comb begin
        w_mean = '0;
        if (r_kept != '0) begin
            if (w_quo > 64'(24'h7fffff) + 64'(r_neg))
                w_mean = r_neg ? ValW'(24'h800000) : ValW'(24'h7fffff);
            else
                w_mean = r_neg ? -ValW'(w_quo) : ValW'(w_quo);
        end
    end

    // shared divider operands: magnitude with half-divisor rounding
    always_comb begin
        if (r_st == S_MDIV) begin
            w_num = 64'(w_rd[SumW-1] ? -{{(64-SumW){w_rd[SumW-1]}}, w_rd}
                                      : {{(64-SumW){1'b0}}, w_rd}) + 64'(r_kept >> 1);
            w_den = RW'(r_kept);
        end else begin
            w_num = (64'(w_mrd[ValW-1] ? -{{(64-ValW){w_mrd[ValW-1]}}, w_mrd}
                                      : {{(64-ValW){1'b0}}, w_mrd}) << 27)
                    + 64'(r_root >> 1);
            w_den = r_root;
        end
    end

    mmpl2_divu #(.NW(64), .DW(RW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(w_num), .i_den(w_den), .o_done(w_ddone), .o_quo(w_quo)
    );

    // sequencing of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_addr <= '0; r_pos <= '0; r_kept <= '0;
            r_rv <= 1'b0; r_done <= 1'b0; r_dstart <= 1'b0; r_msq_v <= 1'b0;
        end else begin
            r_done <= 1'b0; r_dstart <= 1'b0; r_msq_v <= 1'b0;
            if (r_msq_v) r_sq <= r_sq + SqW'(r_msq);
            unique case (r_st)
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(DIM-1)) begin
                        r_st <= S_IDLE; r_addr <= '0; r_pos <= '0; r_kept <= '0;
                    end
                end
                S_IDLE: begin
                    unique case (i_cmd.op)
                        mmpl2_pkg::OP_ACCUM: if (i_cmd.start) begin
                            r_val <= i_val; r_keep <= i_keep; r_addr <= r_pos;
                            if (i_keep && r_pos == '0 && r_kept < KW'(MAX_TOKENS))
                                r_kept <= r_kept + 1'b1;
                            r_pos <= (r_pos == AW'(DIM-1)) ? '0 : r_pos + 1'b1;
                            r_st <= S_ACC_RD;
                        end
                        mmpl2_pkg::OP_MEAN: if (i_cmd.start) begin
                            r_addr <= '0; r_sq <= '0; r_st <= S_MRD;
                        end
                        default: ;
                    endcase
                end
                S_ACC_RD: r_st <= S_ACC_WR;
                S_ACC_WR: begin r_st <= S_IDLE; r_done <= 1'b1; end
                S_MRD: r_st <= S_MWAIT;
                S_MWAIT: begin
                    r_neg <= w_rd[SumW-1];
                    if (r_kept != '0) r_dstart <= 1'b1;
                    r_st <= S_MDIV;
                end
                S_MDIV: begin
                    if (w_ddone || r_kept == '0) begin
                        r_msq <= 48'(w_mean) * 48'(w_mean);
                        r_msq_v <= 1'b1;
                        r_st <= S_MRD;
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == AW'(DIM-1)) begin
                            r_st <= S_ROOT; r_rcnt <= 6'd39; r_addr <= '0;
                        end
                    end
                end
                S_ROOT: begin
                    r_rcnt <= r_rcnt - 1'b1;
                    if (r_rcnt == 6'd0) begin
                        r_root <= r_sres;
                        r_st <= S_ORD;
                    end
                end
                S_ORD: r_st <= S_OWAIT;
                S_OWAIT: begin
                    r_neg <= w_mrd[ValW-1]; r_oidx <= r_addr;
                    if (r_root == '0) r_st <= S_ODIV;
                    else begin r_dstart <= 1'b1; r_st <= S_ODIV; end
                end
                S_ODIV: begin
                    if (w_ddone || r_root == '0) begin
                        logic signed [OutW-1:0] o;
                        if (r_root == '0) o = '0;
                        else if (w_quo > 64'(23'h3fffff) + 64'(r_neg))
                            o = r_neg ? OutW'(23'h400000) : OutW'(23'h3fffff);
                        else o = r_neg ? -OutW'(w_quo) : OutW'(w_quo);
                        r_res <= o; r_rv <= 1'b1; r_st <= S_OSEND;
                    end
                end
                S_OSEND: begin
                    if (r_rv && i_res_ready) begin
                        r_rv <= 1'b0;
                        if (r_oidx == AW'(DIM-1)) begin
                            r_st <= S_CLR; r_addr <= '0; r_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + 1'b1; r_st <= S_ORD;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // digit-recurrence square root, two radicand bits per step
    // load when the last square has landed, then 37 steps
    always_ff @(posedge i_clk) begin
        if (r_st == S_ROOT && r_rcnt == 6'd38) begin
            r_sx <= {r_sq, 10'b0}; r_srem <= '0; r_sres <= '0;
        end else if (r_st == S_ROOT && r_rcnt <= 6'd37 && r_rcnt != 6'd0) begin
            logic [RW+3:0] rem2;
            logic [RW+3:0] trial;
            rem2  = {r_srem, r_sx[SqW+9:SqW+8]};
            trial = {2'b00, r_sres, 2'b01};
            r_sx  <= {r_sx[SqW+7:0], 2'b00};
            if (rem2 >= trial) begin
                r_srem <= (RW+2)'(rem2 - trial);
                r_sres <= {r_sres[RW-2:0], 1'b1};
            end else begin
                r_srem <= (RW+2)'(rem2);
                r_sres <= {r_sres[RW-2:0], 1'b0};
            end
        end
    end

    assign o_sts.busy   = (r_st != S_IDLE);
    assign o_sts.done   = r_done;
    assign o_clear_busy = (r_st == S_CLR);
    assign o_res        = r_res;
    assign o_idx        = mmpl2_pkg::IdxW'(r_oidx);
    assign o_last       = (r_oidx == AW'(DIM-1));
    assign o_res_valid  = r_rv;
endmodule

// ===== rtl/core/mmpl2_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmpl2_ctrl: request controller
// Accepts input requests and commands the datapath per element and at end.
// ----------------------------------------------------------------------------
module mmpl2_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_end,
    output logic            o_ready,
    output mmpl2_pkg::t_cmd o_cmd,
    input  mmpl2_pkg::t_sts i_sts
);
    typedef enum logic [1:0] {C_IDLE, C_ACC, C_FIN} t_cst;

    t_cst r_st;
    logic r_end;
    logic w_acc;

    assign o_ready = (r_st == C_IDLE) && !i_sts.busy;
    assign w_acc   = o_ready && i_valid;

    // command to the datapath
    always_comb begin
        o_cmd.op    = mmpl2_pkg::OP_NONE;
        o_cmd.start = 1'b0;
        if (w_acc) begin
            o_cmd.op = mmpl2_pkg::OP_ACCUM; o_cmd.start = 1'b1;
        end else if (r_st == C_ACC && r_end && !i_sts.busy) begin
            o_cmd.op = mmpl2_pkg::OP_MEAN; o_cmd.start = 1'b1;
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE; r_end <= 1'b0;
        end else begin
            unique case (r_st)
                C_IDLE: if (w_acc) begin r_st <= C_ACC; r_end <= i_end; end
                C_ACC: if (!i_sts.busy) begin
                    r_st <= r_end ? C_FIN : C_IDLE;
                end
                C_FIN: if (i_sts.done) r_st <= C_IDLE;
                default: r_st <= C_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/masked_mean_pool_l2_normalize.sv =====
// ----------------------------------------------------------------------------
// masked_mean_pool_l2_normalize: masked mean pooling with L2 normalization
// Accumulates kept elements per dimension, then emits the normalized means.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  s_in     in   element_value, token_weight, sequence_end
//  m_out    out  pooled_value, dim_index, last_result
//
//  after each accepted element, ready stays low until the sum memory
//  is read, added to and written, and the controller then releases ready
//  closing pass: per dimension, a mean through the 64-step divider; then
//  the root; then per result, a divide plus output backpressure;
//  the divides are skipped when the kept count or the norm is zero
//  after reset and after each sequence the sum memory is swept to zero
//  no input is taken while the closing pass or the sweep runs
module masked_mean_pool_l2_normalize #(
    parameter int unsigned DIM        = 64,
    parameter int unsigned MAX_TOKENS = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmpl2_if.sink     s_in,
    mmpl2_if.source   m_out
);
    mmpl2_pkg::t_cmd w_cmd;
    mmpl2_pkg::t_sts w_sts;
    logic w_clr;
    logic w_rdy;

    mmpl2_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_in.valid),
        .i_end(s_in.data[0]), .o_ready(w_rdy), .o_cmd(w_cmd), .i_sts(w_sts)
    );

    assign s_in.ready = w_rdy && !w_clr;

    mmpl2_dp #(.DIM(DIM), .MAX_TOKENS(MAX_TOKENS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_val(s_in.data[25:2]), .i_keep(s_in.data[1]), .o_clear_busy(w_clr),
        .o_res(m_out.data[29:7]), .o_idx(m_out.data[6:1]), .o_last(m_out.data[0]),
        .o_res_valid(m_out.valid), .i_res_ready(m_out.ready)
    );
endmodule

// ===== sim/tb_masked_mean_pool_l2_normalize.sv =====
// ----------------------------------------------------------------------------
// tb_masked_mean_pool_l2_normalize: self-checking bench for the pooling block
// Drives element requests in bursts, predicts the pooled vectors and checks
// every result against the oldest expected one under random backpressure.
// ----------------------------------------------------------------------------
module tb_masked_mean_pool_l2_normalize;

    localparam int unsigned DIM        = 64;
    localparam int unsigned MAX_TOKENS = 512;
    localparam longint      SUM_HI     = 64'sd8589934591;
    localparam longint      SUM_LO     = -64'sd8589934592;
    localparam longint      MEAN_HI    = 8388607;
    localparam longint      MEAN_LO    = -8388608;
    localparam longint      OUT_HI     = 4194303;
    localparam longint      OUT_LO     = -4194304;

    typedef struct packed {
        logic [mmpl2_pkg::ValW-1:0] value;
        logic                       weight;
        logic                       seq_end;
    } t_elem;

    typedef struct packed {
        logic [mmpl2_pkg::OutW-1:0] pooled;
        logic [mmpl2_pkg::IdxW-1:0] dim;
        logic                       last;
    } t_pooled;

    logic i_clk;
    logic i_rst_n;

    mmpl2_if #(.W($bits(t_elem)))   s_in ();
    mmpl2_if #(.W($bits(t_pooled))) m_out ();

    masked_mean_pool_l2_normalize #(
        .DIM(DIM),
        .MAX_TOKENS(MAX_TOKENS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (s_in.sink),
        .m_out  (m_out.source)
    );

    // predictor state
    longint      acc_sums[DIM];
    int unsigned acc_kept;
    int unsigned acc_pos;

    t_elem   pending_elems[$];
    t_pooled pooled_expected[$];
    int      mismatches;
    bit      stim_done;
    bit      hold_until_drained;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // rounded division, ties away from zero, d > 0
    function automatic longint round_div(longint n, longint d);
        longint mag;
        mag = (n < 0) ? -n : n;
        mag = (mag + d / 2) / d;
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // accumulate one element and emit the vector on sequence end
    task automatic pool_element(t_elem e);
        longint          v;
        longint          means[DIM];
        longint unsigned sq;
        longint unsigned root;
        longint          o;
        t_pooled         p;
        v = longint'($signed(e.value));
        if (e.weight) begin
            acc_sums[acc_pos] = clip(acc_sums[acc_pos] + v, SUM_LO, SUM_HI);
            if (acc_pos == 0 && acc_kept < MAX_TOKENS) acc_kept++;
        end
        acc_pos = (acc_pos + 1 >= DIM) ? 0 : acc_pos + 1;
        if (!e.seq_end) return;
        sq = 0;
        for (int j = 0; j < DIM; j++) begin
            means[j] = 0;
            if (acc_kept != 0)
                means[j] = clip(round_div(acc_sums[j], acc_kept), MEAN_LO, MEAN_HI);
            sq += longint'(means[j] * means[j]);
        end
        root = int_sqrt(sq << 10);
        for (int j = 0; j < DIM; j++) begin
            if (root == 0)
                o = clip(means[j] * 4, OUT_LO, OUT_HI);
            else
                o = clip(round_div(means[j] * (64'sd1 << 27), longint'(root)),
                         OUT_LO, OUT_HI);
            p.pooled = o[mmpl2_pkg::OutW-1:0];
            p.dim    = j[mmpl2_pkg::IdxW-1:0];
            p.last   = (j == DIM - 1);
            pooled_expected = {pooled_expected, p};
        end
        for (int j = 0; j < DIM; j++) acc_sums[j] = 0;
        acc_kept = 0;
        acc_pos  = 0;
    endtask

    function automatic t_elem mk(logic [mmpl2_pkg::ValW-1:0] v, logic w, logic e);
        t_elem x;
        x.value = v; x.weight = w; x.seq_end = e;
        return x;
    endfunction

    function automatic logic [mmpl2_pkg::ValW-1:0] rnd_value();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return mmpl2_pkg::ValW'($urandom_range(0, 255));
            default: return mmpl2_pkg::ValW'($urandom());
        endcase
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // stimulus
    initial begin
        int tokens;
        int bias;
        for (int j = 0; j < DIM; j++) acc_sums[j] = 0;
        acc_kept = 0;
        acc_pos = 0;
        mismatches = 0;
        stim_done = 0;
        hold_until_drained = 0;
        // directed: empty-count sequence, zero norm
        pending_elems = {pending_elems, mk(24'h123456, 1'b0, 1'b1)};
        // one full token at the positive extreme
        for (int j = 0; j < DIM; j++)
            pending_elems = {pending_elems, mk(24'h7FFFFF, 1'b1, j == DIM - 1)};
        // early end with mixed weights: dim 0 skipped so no token counted
        pending_elems = {pending_elems, mk(24'h800000, 1'b0, 1'b0)};
        pending_elems = {pending_elems, mk(24'h800000, 1'b1, 1'b0)};
        pending_elems = {pending_elems, mk(24'h000001, 1'b1, 1'b1)};
        // early end, two kept elements, one token counted
        pending_elems = {pending_elems, mk(24'h800000, 1'b1, 1'b0)};
        pending_elems = {pending_elems, mk(24'hFFFFFF, 1'b1, 1'b1)};
        // random part: short sequences of random tokens and partial tails
        while (pending_elems.size() < 190) begin
            tokens = $urandom_range(0, 1);
            bias = $urandom_range(0, 3);
            for (int t = 0; t < tokens; t++)
                for (int j = 0; j < DIM; j++)
                    pending_elems = {pending_elems, mk(rnd_value(),
                        (bias == 0) ? 1'($urandom()) : 1'b1, 1'b0)};
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 8))
                    pending_elems = {pending_elems,
                        mk(mmpl2_pkg::ValW'($urandom()), 1'($urandom()), 1'b0)};
            end
            pending_elems = {pending_elems, mk(rnd_value(), 1'($urandom()), 1'b1)};
        end
    end

    // reset
    initial begin
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: bursts with random gaps, one drained pause mid-run
    int  burst_left;
    int  gap_left;
    int  sent;
    initial begin
        s_in.valid = 1'b0;
        s_in.data  = '0;
        burst_left = 0;
        gap_left   = 0;
        sent       = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_in.valid && s_in.ready) begin
                pool_element(t_elem'(s_in.data));
                void'(pending_elems.pop_front());
                sent <= sent + 1;
                if (sent == 150) hold_until_drained = 1;
            end
            if (hold_until_drained && pooled_expected.size() == 0) hold_until_drained = 0;
            if (pending_elems.size() == 0) begin
                s_in.valid <= 1'b0;
                stim_done  <= 1'b1;
            end else if (s_in.valid && !s_in.ready) begin
                // keep holding the request
            end else if (hold_until_drained) begin
                s_in.valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                s_in.valid <= 1'b0;
            end else begin
                s_in.valid <= 1'b1;
                s_in.data  <= pending_elems[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase;
    initial begin
        m_out.ready = 1'b0;
        stall_phase = 0;
    end

    always @(posedge i_clk) begin
        t_pooled got;
        t_pooled exp_p;
        if (i_rst_n) begin
            stall_phase <= stall_phase + 1;
            if ((stall_phase / 200) % 2 == 0)
                m_out.ready <= 1'b1;
            else
                m_out.ready <= ($urandom_range(0, 3) != 0);
            if (m_out.valid && m_out.ready) begin
                got = t_pooled'(m_out.data);
                if (pooled_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result dim=%0d value=%h", got.dim, got.pooled);
                end else begin
                    exp_p = pooled_expected.pop_front();
                    if (got !== exp_p) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp v=%h d=%0d l=%b got v=%h d=%0d l=%b",
                                     exp_p.pooled, exp_p.dim, exp_p.last,
                                     got.pooled, got.dim, got.last);
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (pooled_expected.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pooled_expected.size() == 0)
            $display("tb_masked_mean_pool_l2_normalize: PASS");
        else
            $display("tb_masked_mean_pool_l2_normalize: FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #100000000;
        $display("tb_masked_mean_pool_l2_normalize: FAIL");
        $finish;
    end

endmodule
